// File: rtl/core/petri_net_token_engine_unit_macros.svh
// Assertion helpers for the token engine
`ifndef PETRI_NET_TOKEN_ENGINE_UNIT_MACROS_SVH
`define PETRI_NET_TOKEN_ENGINE_UNIT_MACROS_SVH
// property must hold on every clock unless in reset
`define PN_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication checked in the next cycle
`define PN_ASSERT_NEXT(lbl, clk, rst_n, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

// File: rtl/core/pnte_pkg.sv
`default_nettype none
package pnte_pkg;
	localparam int PLACE_COUNT      = 16;
	localparam int TRANSITION_COUNT = 16;
	localparam int ARC_CAPACITY     = 64;
	localparam int MARK_BITS        = 16;
	localparam int PW = 4;
	localparam int TW = 4;
	localparam int AW = 6;
	localparam int CW = 7;

	localparam logic [2:0] OP_ADD_ARC = 3'd0;
	localparam logic [2:0] OP_SET_INIT = 3'd1;
	localparam logic [2:0] OP_RESTART = 3'd2;
	localparam logic [2:0] OP_OFFER = 3'd3;
	localparam logic [2:0] OP_READ = 3'd4;

	localparam logic [1:0] KIND_IN = 2'd0;
	localparam logic [1:0] KIND_OUT = 2'd1;
	localparam logic [1:0] KIND_INH = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;
	localparam logic [1:0] ST_SAT = 2'd3;

	typedef struct packed {
		logic [2:0]  operation;
		logic [3:0]  trans_id;
		logic [3:0]  place_id;
		logic [1:0]  arc_kind;
		logic [15:0] token_value;
		logic [31:0] sample_delay;
		logic        last_offer;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        fired;
		logic [3:0]  fired_transition;
		logic [47:0] current_time;
		logic [15:0] mark_out;
	} rsp_t;

	typedef struct packed {
		logic [TW-1:0]        trans;
		logic [PW-1:0]        place;
		logic [1:0]           kind;
		logic [MARK_BITS-1:0] mult;
	} arc_t;
endpackage
`default_nettype wire

// File: rtl/core/pnte_arc_mem.sv
`default_nettype none
module pnte_arc_mem
	import pnte_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire arc_t          wdata,
	input  wire logic [AW-1:0] raddr,
	output arc_t               rdata
);
	arc_t mem [ARC_CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/core/pnte_mark_mem.sv
`default_nettype none
module pnte_mark_mem
	import pnte_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 clr,
	input  wire logic                 we,
	input  wire logic [PW-1:0]        waddr,
	input  wire logic [MARK_BITS-1:0] wdata,
	input  wire logic [PW-1:0]        raddr,
	output logic [MARK_BITS-1:0]      rdata
);
	// valid bits give the reset value of zero
	logic [MARK_BITS-1:0] mem [PLACE_COUNT];
	logic [PLACE_COUNT-1:0] vld_q;
	logic rvld_q;
	logic [MARK_BITS-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rvld_q <= 1'b0;
		end else begin
			rvld_q <= vld_q[raddr] && !clr;
			if (clr) begin
				vld_q <= '0;
			end
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
		end
	end

	assign rdata = rvld_q ? rd_q : '0;
endmodule
`default_nettype wire

// File: rtl/core/petri_net_token_engine_unit.sv
`default_nettype none
// Petri net token engine: race-firing core of a stochastic Petri net.
// Command channel: cmd is taken at a clock edge with start high and busy low.
// Result channel: rsp is valid for one cycle while done is high; the receiver
// cannot stall it, so one result beat leaves for every accepted command.
// Steps from the accepting edge to the result beat, by command:
//   add arc, set initial mark, unused codes: dispatch, then the done state
//   read mark: mark memory read, then registered out
//   restart: initial marks copied per place (read, then write)
//   offer sample, or last offer with no winner: the enable check walks the
//   arc table, each entry read as arc, then mark, then compared
//   last offer with a winner: two more walks (inputs, then outputs), each
//   entry read as arc, then mark, checked, then written back
// Throughput: one command in flight; the next is taken the cycle after the beat.
// Each fire step reads the mark memory, then writes it back; the next read
// comes only after that write (interlock).
// Reset clears the marks (through valid bits), arc count, time and round.
// The arc table needs no clearing; only entries below the count are read.
module petri_net_token_engine_unit
	import pnte_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire cmd_t cmd,
	output logic      busy,
	output logic      done,
	output rsp_t      rsp
);
	`include "petri_net_token_engine_unit_macros.svh"

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_RST_RD, S_RST_WR, S_READ_WAIT, S_READ_OUT,
		S_EN_RD, S_EN_ARC, S_EN_MARK, S_DECIDE, S_FIRE_RD, S_FIRE_ARC,
		S_FIRE_MARK, S_FIRE_WR, S_DONE
	} state_t;

	state_t state_q;
	cmd_t cmd_q;
	logic [CW-1:0] total_q, idx_q;
	logic [47:0] time_q;
	logic [31:0] best_delay_q;
	logic [TW-1:0] best_t_q;
	logic have_q, enabled_q, pass_out_q, sat_q, hit_q;
	logic [PW-1:0] rst_p_q;
	arc_t arc_q;
	rsp_t rsp_q;
	logic done_q;

	// arc memory
	logic arc_we;
	arc_t arc_wd, arc_rd;
	assign arc_we = (state_q == S_DISPATCH) && cmd_q.operation == OP_ADD_ARC
		&& total_q != CW'(ARC_CAPACITY) && cmd_q.arc_kind != KIND_NONE;
	assign arc_wd = '{trans: cmd_q.trans_id, place: cmd_q.place_id,
		kind: cmd_q.arc_kind, mult: cmd_q.token_value};
	pnte_arc_mem u_arc (.clk, .we(arc_we), .waddr(total_q[AW-1:0]), .wdata(arc_wd),
		.raddr(idx_q[AW-1:0]), .rdata(arc_rd));

	// initial marks
	logic init_we;
	logic [MARK_BITS-1:0] init_rd;
	assign init_we = (state_q == S_DISPATCH) && cmd_q.operation == OP_SET_INIT;
	pnte_mark_mem u_init (.clk, .arst_n, .clr(1'b0), .we(init_we),
		.waddr(cmd_q.place_id), .wdata(cmd_q.token_value), .raddr(rst_p_q),
		.rdata(init_rd));

	// current marks
	logic cur_we;
	logic [PW-1:0] cur_wa, cur_ra;
	logic [MARK_BITS-1:0] cur_wd, cur_rd;
	logic [MARK_BITS:0] add_sum;
	assign add_sum = {1'b0, cur_rd} + {1'b0, arc_q.mult};
	always_comb begin
		cur_we = 1'b0;
		cur_wa = arc_q.place;
		cur_wd = '0;
		// read mark holds its address through dispatch and the read wait; arc walks
		// address straight from the arc memory output
		if (state_q == S_DISPATCH || state_q == S_READ_WAIT) begin
			cur_ra = cmd_q.place_id;
		end else if (state_q == S_EN_ARC || state_q == S_FIRE_ARC) begin
			cur_ra = arc_rd.place;
		end else begin
			cur_ra = arc_q.place;
		end
		if (state_q == S_RST_WR) begin
			cur_we = 1'b1;
			cur_wa = rst_p_q;
			cur_wd = init_rd;
		end else if (state_q == S_FIRE_WR) begin
			cur_we = hit_q;
			if (pass_out_q) begin
				cur_wd = add_sum[MARK_BITS] ? '1 : add_sum[MARK_BITS-1:0];
			end else begin
				cur_wd = (cur_rd > arc_q.mult) ? cur_rd - arc_q.mult : '0;
			end
		end
	end
	pnte_mark_mem u_cur (.clk, .arst_n, .clr(1'b0), .we(cur_we), .waddr(cur_wa),
		.wdata(cur_wd), .raddr(cur_ra), .rdata(cur_rd));

	logic [48:0] time_sum;
	assign time_sum = {1'b0, time_q} + {17'd0, best_delay_q};

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_q <= cmd;
		end
		if (state_q == S_EN_ARC || state_q == S_FIRE_ARC) begin
			arc_q <= arc_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
			idx_q <= '0;
			time_q <= '0;
			best_delay_q <= '1;
			best_t_q <= '0;
			have_q <= 1'b0;
			enabled_q <= 1'b0;
			pass_out_q <= 1'b0;
			sat_q <= 1'b0;
			hit_q <= 1'b0;
			rst_p_q <= '0;
			done_q <= 1'b0;
			rsp_q.status <= ST_OK;
			rsp_q.fired <= 1'b0;
			rsp_q.fired_transition <= '0;
			rsp_q.current_time <= '0;
			rsp_q.mark_out <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start && !busy) begin
						state_q <= S_DISPATCH;
						rsp_q.status <= ST_OK;
						rsp_q.fired <= 1'b0;
						rsp_q.fired_transition <= '0;
						rsp_q.mark_out <= '0;
						idx_q <= '0;
						rst_p_q <= '0;
						enabled_q <= 1'b1;
						sat_q <= 1'b0;
						hit_q <= 1'b0;
						pass_out_q <= 1'b0;
					end
				end
				S_DISPATCH: begin
					state_q <= S_DONE;
					unique case (cmd_q.operation)
						OP_ADD_ARC: begin
							if (total_q == CW'(ARC_CAPACITY)) begin
								rsp_q.status <= ST_FULL;
							end else if (cmd_q.arc_kind != KIND_NONE) begin
								total_q <= total_q + 1'b1;
							end
						end
						OP_RESTART: begin
							time_q <= '0;
							have_q <= 1'b0;
							best_delay_q <= '1;
							best_t_q <= '0;
							state_q <= S_RST_RD;
						end
						OP_OFFER: state_q <= (total_q == '0) ? S_DECIDE : S_EN_RD;
						OP_READ: state_q <= S_READ_WAIT;
						default: ;
					endcase
				end
				S_RST_RD: state_q <= S_RST_WR;
				S_RST_WR: begin
					rst_p_q <= rst_p_q + 1'b1;
					state_q <= (rst_p_q == PW'(PLACE_COUNT - 1)) ? S_DONE : S_RST_RD;
				end
				S_READ_WAIT: state_q <= S_READ_OUT;
				S_READ_OUT: begin
					rsp_q.mark_out <= cur_rd;
					state_q <= S_DONE;
				end
				S_EN_RD: state_q <= S_EN_ARC;
				S_EN_ARC: state_q <= S_EN_MARK;
				S_EN_MARK: begin
					if (arc_q.trans == cmd_q.trans_id) begin
						if (arc_q.kind == KIND_IN && arc_q.mult > cur_rd) begin
							enabled_q <= 1'b0;
						end
						if (arc_q.kind == KIND_INH && arc_q.mult < cur_rd) begin
							enabled_q <= 1'b0;
						end
					end
					idx_q <= idx_q + 1'b1;
					state_q <= (idx_q + 1'b1 == total_q) ? S_DECIDE : S_EN_RD;
				end
				S_DECIDE: begin
					idx_q <= '0;
					hit_q <= 1'b0;
					if (enabled_q && (!have_q || cmd_q.sample_delay < best_delay_q)) begin
						have_q <= 1'b1;
						best_delay_q <= cmd_q.sample_delay;
						best_t_q <= cmd_q.trans_id;
					end
					if (!cmd_q.last_offer) begin
						state_q <= S_DONE;
					end else if (!have_q && !enabled_q) begin
						rsp_q.status <= ST_NONE;
						best_delay_q <= '1;
						best_t_q <= '0;
						state_q <= S_DONE;
					end else begin
						state_q <= (total_q == '0) ? S_FIRE_WR : S_FIRE_RD;
						pass_out_q <= (total_q == '0);
					end
				end
				S_FIRE_RD: state_q <= S_FIRE_ARC;
				S_FIRE_ARC: state_q <= S_FIRE_MARK;
				S_FIRE_MARK: begin
					state_q <= S_FIRE_WR;
					hit_q <= 1'b0;
					if (arc_q.trans == best_t_q
						&& arc_q.kind == (pass_out_q ? KIND_OUT : KIND_IN)) begin
						hit_q <= 1'b1;
						if (pass_out_q && add_sum[MARK_BITS]) begin
							sat_q <= 1'b1;
						end
					end
				end
				S_FIRE_WR: begin
					idx_q <= idx_q + 1'b1;
					if (total_q == '0 || idx_q + 1'b1 == total_q) begin
						idx_q <= '0;
						if (pass_out_q) begin
							rsp_q.fired <= 1'b1;
							rsp_q.fired_transition <= best_t_q;
							rsp_q.status <= sat_q ? ST_SAT : ST_OK;
							time_q <= time_sum[48] ? '1 : time_sum[47:0];
							have_q <= 1'b0;
							best_delay_q <= '1;
							best_t_q <= '0;
							state_q <= S_DONE;
						end else begin
							pass_out_q <= 1'b1;
							state_q <= S_FIRE_RD;
						end
					end else begin
						state_q <= S_FIRE_RD;
					end
				end
				S_DONE: begin
					done_q <= 1'b1;
					rsp_q.current_time <= time_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE) || done_q;
	assign done = done_q;
	assign rsp = rsp_q;

	`PN_ASSERT(a_count_bound, clk, arst_n, total_q <= CW'(ARC_CAPACITY), "arc count overflow")
	`PN_ASSERT_NEXT(a_done_pulse, clk, arst_n, done_q, !done_q, "done held two cycles")
	`PN_ASSERT(a_busy_done, clk, arst_n, !done_q || busy, "done while not busy")
	`PN_ASSERT(a_fired_ok, clk, arst_n, !(done_q && rsp_q.fired) || rsp_q.status != ST_NONE,
		"fired with no candidate")
endmodule
`default_nettype wire

// File: tb/sv/tb_petri_net_token_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Self-checking bench for the token engine.
// Commands go in on start/busy; every accepted command gives exactly one
// result beat on done, compared against a behavioral model of the net kept
// here (arc table, initial and current marks, time, race round).
module tb_petri_net_token_engine_unit;
	import pnte_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 250;
	localparam logic [2:0] OP_SPARE = 3'd5;
	localparam logic [2:0] OP_TOP_SPARE = 3'd7;
	localparam logic [MARK_BITS-1:0] MARK_TOP = '1;
	localparam logic [47:0] TIME_TOP = '1;

	logic clk;
	logic arst_n;
	logic start;
	cmd_t cmd;
	logic busy;
	logic done;
	rsp_t rsp;

	petri_net_token_engine_unit uut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done),
		.rsp   (rsp)
	);

	// 12 ns clock
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---- net model -------------------------------------------------------
	arc_t                 net_arcs [ARC_CAPACITY];
	int                   net_arc_count;
	logic [MARK_BITS-1:0] net_init [PLACE_COUNT];
	logic [MARK_BITS-1:0] net_mark [PLACE_COUNT];
	logic [47:0]          net_time;
	logic [31:0]          race_delay;
	logic [3:0]           race_winner;
	logic                 race_open;

	rsp_t pending_rsp [$];
	int   mismatches;
	int   idle_pct;
	int   quiet_cycles;

	function automatic void clear_round();
		race_open   = 1'b0;
		race_delay  = '1;
		race_winner = '0;
	endfunction

	// input arcs need mark >= mult, inhibitor arcs need mark <= mult
	function automatic logic trans_enabled(logic [3:0] t);
		for (int i = 0; i < net_arc_count; i++) begin
			if (net_arcs[i].trans == t) begin
				if (net_arcs[i].kind == KIND_IN && net_arcs[i].mult > net_mark[net_arcs[i].place])
					return 1'b0;
				if (net_arcs[i].kind == KIND_INH && net_arcs[i].mult < net_mark[net_arcs[i].place])
					return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// consume on inputs (clamp at zero), then produce on outputs (saturate)
	function automatic logic fire_winner(logic [3:0] t);
		logic        sat;
		logic [16:0] sum;
		sat = 1'b0;
		for (int i = 0; i < net_arc_count; i++) begin
			if (net_arcs[i].trans == t && net_arcs[i].kind == KIND_IN) begin
				if (net_mark[net_arcs[i].place] > net_arcs[i].mult)
					net_mark[net_arcs[i].place] -= net_arcs[i].mult;
				else
					net_mark[net_arcs[i].place] = '0;
			end
		end
		for (int i = 0; i < net_arc_count; i++) begin
			if (net_arcs[i].trans == t && net_arcs[i].kind == KIND_OUT) begin
				sum = {1'b0, net_mark[net_arcs[i].place]} + {1'b0, net_arcs[i].mult};
				if (sum > {1'b0, MARK_TOP}) begin
					sum = {1'b0, MARK_TOP};
					sat = 1'b1;
				end
				net_mark[net_arcs[i].place] = sum[15:0];
			end
		end
		return sat;
	endfunction

	function automatic rsp_t net_step(cmd_t c);
		rsp_t        r;
		logic [48:0] nt;
		r = '0;
		case (c.operation)
			OP_ADD_ARC: begin
				if (net_arc_count >= ARC_CAPACITY)
					r.status = ST_FULL;
				else if (c.arc_kind != KIND_NONE) begin
					net_arcs[net_arc_count] = '{c.trans_id, c.place_id,
						c.arc_kind, c.token_value};
					net_arc_count++;
				end
			end
			OP_SET_INIT: net_init[c.place_id] = c.token_value;
			OP_RESTART: begin
				net_mark = net_init;
				net_time = '0;
				clear_round();
			end
			OP_OFFER: begin
				if (trans_enabled(c.trans_id) &&
						(!race_open || c.sample_delay < race_delay)) begin
					race_open   = 1'b1;
					race_delay  = c.sample_delay;
					race_winner = c.trans_id;
				end
				if (c.last_offer) begin
					if (race_open) begin
						nt = {1'b0, net_time} + {17'b0, race_delay};
						if (fire_winner(race_winner))
							r.status = ST_SAT;
						net_time = nt > {1'b0, TIME_TOP} ? TIME_TOP : nt[47:0];
						r.fired = 1'b1;
						r.fired_transition = race_winner;
					end else
						r.status = ST_NONE;
					clear_round();
				end
			end
			OP_READ: r.mark_out = net_mark[c.place_id];
			default: ;
		endcase
		r.current_time = net_time;
		return r;
	endfunction

	// ---- command driver -----------------------------------------------------
	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic issue(cmd_t c, logic has_typed, rsp_t typed);
		rsp_t predicted;
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		cmd   = c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = net_step(c);
		pending_rsp.insert(pending_rsp.size(), has_typed ? typed : predicted);
		@(negedge clk);
	endtask

	function automatic cmd_t mk(logic [2:0] op, logic [3:0] t, logic [3:0] p,
			logic [1:0] k, logic [15:0] v, logic [31:0] d, logic last);
		cmd_t c;
		c = '{op, t, p, k, v, d, last};
		return c;
	endfunction

	function automatic rsp_t mk_rsp(logic [1:0] st, logic f, logic [3:0] ft,
			logic [47:0] tm, logic [15:0] m);
		rsp_t r;
		r = '{st, f, ft, tm, m};
		return r;
	endfunction

	// weighted random command; small values dominate so nets actually enable
	function automatic cmd_t rand_cmd();
		cmd_t c;
		int   pick;
		c = '0;
		c.trans_id = 4'($urandom_range(15));
		c.place_id = 4'($urandom_range(15));
		c.arc_kind = ($urandom_range(19) == 0) ? KIND_NONE : 2'($urandom_range(2));
		case ($urandom_range(3))
			0: c.token_value = 16'($urandom);
			1: c.token_value = ($urandom_range(1) != 0) ? 16'hFFFF :
				16'hFFF0 + 16'($urandom_range(15));
			default: c.token_value = 16'($urandom_range(4));
		endcase
		c.sample_delay = ($urandom_range(2) == 0) ? $urandom : $urandom_range(300);
		if ($urandom_range(19) == 0)
			c.sample_delay = '1;
		c.last_offer = $urandom_range(2) == 0;
		pick = $urandom_range(99);
		if (pick < 14)      c.operation = OP_ADD_ARC;
		else if (pick < 24) c.operation = OP_SET_INIT;
		else if (pick < 29) c.operation = OP_RESTART;
		else if (pick < 82) c.operation = OP_OFFER;
		else if (pick < 97) c.operation = OP_READ;
		else                c.operation = OP_SPARE + 3'($urandom_range(2));
		return c;
	endfunction

	// ---- result checker -----------------------------------------------------
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result beat with nothing outstanding: %p", $realtime, rsp);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status || rsp.fired !== want.fired ||
						rsp.fired_transition !== want.fired_transition ||
						rsp.current_time !== want.current_time ||
						rsp.mark_out !== want.mark_out) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch exp %p got %p", $realtime, want, rsp);
				end
			end
		end
	end

	// watchdog: cycles with neither a command nor a result beat
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[petri_net_token_engine_unit] ERROR");
			$finish;
		end
	end

	// ---- directed table -----------------------------------------------------
	typedef struct {
		cmd_t c;
		logic has_typed;
		rsp_t r;
	} row_t;

	row_t rows [$];

	function automatic void add_row(cmd_t c, logic has_typed, rsp_t r);
		row_t e;
		e.c         = c;
		e.has_typed = has_typed;
		e.r         = r;
		rows.insert(rows.size(), e);
	endfunction

	initial begin
		cmd_t c;
		int   phase;
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = '0;
		mismatches   = 0;
		idle_pct     = 0;
		quiet_cycles = 0;
		net_arc_count = 0;
		net_time     = '0;
		for (int i = 0; i < PLACE_COUNT; i++) begin
			net_init[i] = '0;
			net_mark[i] = '0;
		end
		clear_round();

		// after reset: all marks zero, time zero
		add_row(mk(OP_READ, 0, 15, 0, 0, 0, 0), 1'b1, mk_rsp(ST_OK, 0, 0, 0, 0));
		// no arcs: any transition is enabled; all-ones delay wins
		add_row(mk(OP_OFFER, 15, 0, 0, 0, '1, 1), 1'b1,
			mk_rsp(ST_OK, 1, 15, 48'hFFFF_FFFF, 0));
		// restart brings time back to zero
		add_row(mk(OP_RESTART, 0, 0, 0, 0, 0, 0), 1'b1, mk_rsp(ST_OK, 0, 0, 0, 0));
		add_row(mk(OP_SET_INIT, 0, 0, 0, 16'hFFFF, 0, 0), 1'b1, mk_rsp(ST_OK, 0, 0, 0, 0));
		add_row(mk(OP_SET_INIT, 0, 1, 0, 0, 0, 0), 1'b0, '0);
		add_row(mk(OP_SET_INIT, 0, 2, 0, 3, 0, 0), 1'b0, '0);
		add_row(mk(OP_RESTART, 0, 0, 0, 0, 0, 0), 1'b0, '0);
		add_row(mk(OP_ADD_ARC, 1, 0, KIND_IN, 1, 0, 0), 1'b0, '0);
		add_row(mk(OP_ADD_ARC, 1, 1, KIND_OUT, 16'hFFFF, 0, 0), 1'b0, '0);
		add_row(mk(OP_ADD_ARC, 2, 1, KIND_INH, 0, 0, 0), 1'b0, '0);
		add_row(mk(OP_ADD_ARC, 3, 2, KIND_IN, 16'hFFFF, 0, 0), 1'b0, '0);
		// arc kind three stores nothing
		add_row(mk(OP_ADD_ARC, 4, 4, KIND_NONE, 1, 0, 0), 1'b0, '0);
		add_row(mk(OP_SPARE, '1, '1, '1, '1, '1, 1), 1'b0, '0);
		add_row(mk(OP_TOP_SPARE, 0, 0, 0, 0, 0, 0), 1'b0, '0);
		// ties keep the first offer; disabled offers are ignored
		add_row(mk(OP_OFFER, 1, 0, 0, 0, 5, 0), 1'b0, '0);
		add_row(mk(OP_OFFER, 2, 0, 0, 0, 5, 0), 1'b0, '0);
		add_row(mk(OP_OFFER, 3, 0, 0, 0, 0, 0), 1'b0, '0);
		add_row(mk(OP_OFFER, 2, 0, 0, 0, 7, 1), 1'b0, '0);
		// second firing pushes place 1 past the top: saturation status
		add_row(mk(OP_OFFER, 1, 0, 0, 0, 0, 1), 1'b0, '0);
		add_row(mk(OP_READ, 0, 1, 0, 0, 0, 0), 1'b0, '0);
		// inhibitor blocks t2 and no one else offers: no enabled transition
		add_row(mk(OP_OFFER, 2, 0, 0, 0, 9, 1), 1'b0, '0);
		add_row(mk(OP_READ, 0, 0, 0, 0, 0, 0), 1'b0, '0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i])
			issue(rows[i].c, rows[i].has_typed, rows[i].r);

		// random part in four idling phases
		for (int n = 0; n < 950; n++) begin
			phase = n / 238;
			case (phase)
				0: idle_pct = 0;
				1: idle_pct = 69;
				2: idle_pct = 0;
				default: idle_pct = 35;
			endcase
			c = rand_cmd();
			issue(c, 1'b0, '0);
		end
		start = 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("[petri_net_token_engine_unit] OK");
		else
			$display("[petri_net_token_engine_unit] ERROR");
		$finish;
	end
endmodule
`default_nettype wire

// File: petri_net_token_engine_unit.f
+incdir+rtl/core
rtl/core/pnte_pkg.sv
rtl/core/pnte_arc_mem.sv
rtl/core/pnte_mark_mem.sv
rtl/core/petri_net_token_engine_unit.sv
tb/sv/tb_petri_net_token_engine_unit.sv
